// File: design/glyph_text_measure_top_macros.svh
// Assertion macros for the glyph text measurer.
// Used by glyph_text_measure_top; no other dependencies.
`ifndef GLYPH_TEXT_MEASURE_TOP_MACROS_SVH
`define GLYPH_TEXT_MEASURE_TOP_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define GTM_AST_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
// condition holds at every edge out of reset
`define GTM_AST_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("invariant check failed");
`else
`define GTM_AST_IMPL(label, clk, rst_n, ante, cons)
`define GTM_AST_ALWAYS(label, clk, rst_n, cond)
`endif
`endif

// File: design/gtm_pkg.sv
// Package for the glyph text measurer: sizes, field widths, codes.
// No dependencies.
package gtm_pkg;
	// glyph table
	localparam int GLYPH_SLOTS = 256;
	localparam int SLOT_W      = $clog2(GLYPH_SLOTS);
	localparam int CNT_W       = $clog2(GLYPH_SLOTS + 1);

	// field widths
	localparam int LH_W    = 10;
	localparam int GC_W    = 9;
	localparam int IDX_W   = 8;
	localparam int CODE_W  = 21;
	localparam int ADV_W   = 12;
	localparam int PEN_W   = 24;
	localparam int WID_W   = 23;
	localparam int HGT_W   = 24;
	localparam int MISS_W  = 16;
	localparam int ENTRY_W = CODE_W + ADV_W;

	// stream packing
	localparam int IN_BITS  = IDX_W + CODE_W + ADV_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = WID_W + HGT_W + MISS_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// configuration register indexes
	localparam logic [1:0] REG_LINE_HEIGHT  = 2'd0;
	localparam logic [1:0] REG_GLYPH_COUNT  = 2'd1;
	localparam logic [1:0] REG_MEASURE_MODE = 2'd2;

	// opcodes
	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_MEASURE = 1'b1;

	// special code points
	localparam logic [CODE_W-1:0] CODE_END = 21'd0;
	localparam logic [CODE_W-1:0] CODE_LF  = 21'd10;
	localparam logic [CODE_W-1:0] CODE_CR  = 21'd13;

	localparam logic [MISS_W-1:0] MISS_MAX   = '1;
	localparam logic [HGT_W-1:0]  HEIGHT_MAX = '1;
	localparam logic MODE_LINE = 1'b1;
endpackage

// File: design/glyph_text_measure_top.sv
// Glyph text measurer: glyph table RAM, binary search sequencer, pen accumulate.
// Depends on gtm_pkg and glyph_text_measure_top_macros.svh.
// Flow: a load, a LF or CR, or a character with an empty table is handled in ST_IDLE alone;
// a searched character goes on to ST_PROBE, then to ST_ACC when found, making at most
// log2(GLYPH_SLOTS)+1 table probes (9 for 256 slots), one a cycle through the single
// read port. A terminator (LF/CR too in line mode) goes on to ST_FINISH, which registers
// the result and sets it valid; it stalls there while the previous result is not taken.
// Reset (arst_n low, asynchronous) clears control, config and measurement state only.
`include "glyph_text_measure_top_macros.svh"

module glyph_text_measure_top
	import gtm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// entry_index [7:0], code_point [28:8], advance [40:29], zero fill above
	input  logic [IN_W-1:0]       s_tdata,
	// opcode
	input  logic                  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// text_width [22:0], text_height [46:23], miss_count [62:47], zero fill above
	output logic [OUT_W-1:0]      m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [LH_W-1:0]       cfg_data
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_PROBE  = 2'd1;
	localparam logic [1:0] ST_ACC    = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]              state_q;
	logic [LH_W-1:0]         line_height_q;
	logic [GC_W-1:0]         glyph_count_q;
	logic                    measure_mode_q;
	logic signed [PEN_W-1:0] pen_q;
	logic [WID_W-1:0]        widest_q;
	logic [HGT_W-1:0]        height_q;
	logic [MISS_W-1:0]       misses_q;
	logic                    in_string_q;
	logic [SLOT_W-1:0]       lo_q, hi_q, mid_q;
	logic [CODE_W-1:0]       code_q;
	logic                    m_tvalid_q;
	logic [OUT_W-1:0]        m_tdata_q;

	// glyph table: code in the low bits, advance above
	logic [ENTRY_W-1:0]      glyph_mem [GLYPH_SLOTS];
	logic [ENTRY_W-1:0]      rd_q;
	logic                    rd_en;
	logic [SLOT_W-1:0]       rd_addr;
	logic                    wr_en;

	// input fields
	logic [IDX_W-1:0]        in_index;
	logic [CODE_W-1:0]       in_code;
	logic [ADV_W-1:0]        in_adv;
	logic                    accept;
	logic                    acc_measure;

	assign in_index = s_tdata[IDX_W-1:0];
	assign in_code  = s_tdata[IDX_W +: CODE_W];
	assign in_adv   = s_tdata[IDX_W+CODE_W +: ADV_W];

	assign s_tready    = (state_q == ST_IDLE);
	assign accept      = s_tvalid && s_tready;
	assign acc_measure = accept && (s_tuser == OP_MEASURE);
	assign wr_en       = accept && (s_tuser == OP_LOAD) && (int'(in_index) < GLYPH_SLOTS);
	assign cfg_ready   = 1'b1;
	assign m_tvalid    = m_tvalid_q;
	assign m_tdata     = m_tdata_q;

	// table RAM: one write port for loads, one registered read port for probes.
	// Loads and searches never overlap, one item being in flight at a time.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			glyph_mem[SLOT_W'(in_index)] <= {in_adv, in_code};
		end
		if (rd_en) begin
			rd_q <= glyph_mem[rd_addr];
		end
	end

	// measurement values as seen by an item that may open a new string
	logic signed [PEN_W-1:0] pen_b;
	logic [WID_W-1:0]        widest_b;
	logic [MISS_W-1:0]       misses_b;
	logic [HGT_W-1:0]        height_b;
	logic [HGT_W:0]          height_sum;
	logic [HGT_W-1:0]        height_lf;
	logic [MISS_W-1:0]       misses_b_inc;
	logic [MISS_W-1:0]       misses_q_inc;

	always_comb begin
		pen_b        = in_string_q ? pen_q : '0;
		widest_b     = in_string_q ? widest_q : '0;
		misses_b     = in_string_q ? misses_q : '0;
		height_b     = in_string_q ? height_q : HGT_W'(line_height_q);
		height_sum   = {1'b0, height_b} + (HGT_W+1)'(line_height_q);
		height_lf    = height_sum[HGT_W] ? HEIGHT_MAX : height_sum[HGT_W-1:0];
		misses_b_inc = (misses_b == MISS_MAX) ? misses_b : misses_b + 1'b1;
		misses_q_inc = (misses_q == MISS_MAX) ? misses_q : misses_q + 1'b1;
	end

	// search bounds at string lookup start
	logic [CNT_W-1:0]  n_slots;
	logic [SLOT_W-1:0] hi_init;
	logic              is_special;

	always_comb begin
		n_slots    = (int'(glyph_count_q) > GLYPH_SLOTS) ? CNT_W'(GLYPH_SLOTS)
		                                                  : CNT_W'(glyph_count_q);
		hi_init    = SLOT_W'(n_slots - 1'b1);
		is_special = (in_code == CODE_END) || (in_code == CODE_LF) || (in_code == CODE_CR);
	end

	// one probe step: compare the entry just read, pick the next midpoint
	logic [CODE_W-1:0] rd_code;
	logic [SLOT_W:0]   lo_up;
	logic [SLOT_W-1:0] hi_dn;
	logic [SLOT_W:0]   sum_up, sum_dn;
	logic              probe_hit, probe_gt, probe_miss;
	logic [SLOT_W-1:0] probe_mid;

	always_comb begin
		rd_code    = rd_q[CODE_W-1:0];
		lo_up      = (SLOT_W+1)'(mid_q) + 1'b1;
		hi_dn      = mid_q - 1'b1;
		sum_up     = (SLOT_W+1)'(lo_up[SLOT_W-1:0]) + (SLOT_W+1)'(hi_q);
		sum_dn     = (SLOT_W+1)'(lo_q) + (SLOT_W+1)'(hi_dn);
		probe_hit  = (code_q == rd_code);
		probe_gt   = (code_q > rd_code);
		probe_miss = probe_gt ? (lo_up > (SLOT_W+1)'(hi_q)) : (mid_q == lo_q);
		probe_mid  = probe_gt ? sum_up[SLOT_W:1] : sum_dn[SLOT_W:1];
	end

	// read port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = probe_mid;
		if (state_q == ST_IDLE) begin
			rd_en   = acc_measure && !is_special && (n_slots != '0);
			rd_addr = hi_init >> 1;
		end else if (state_q == ST_PROBE) begin
			rd_en   = !probe_hit && !probe_miss;
		end
	end

	// pen update for a found glyph
	logic signed [PEN_W:0]   pen_sum;
	logic signed [PEN_W-1:0] pen_next;

	always_comb begin
		pen_sum = (PEN_W+1)'(pen_q) + (PEN_W+1)'($signed(rd_q[ENTRY_W-1:CODE_W]));
		if (pen_sum[PEN_W] != pen_sum[PEN_W-1]) begin
			pen_next = pen_sum[PEN_W] ? {1'b1, {(PEN_W-1){1'b0}}} : {1'b0, {(PEN_W-1){1'b1}}};
		end else begin
			pen_next = pen_sum[PEN_W-1:0];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_height_q  <= '0;
			glyph_count_q  <= '0;
			measure_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LINE_HEIGHT:  line_height_q  <= cfg_data;
				REG_GLYPH_COUNT:  glyph_count_q  <= cfg_data[GC_W-1:0];
				REG_MEASURE_MODE: measure_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer and measurement state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_string_q <= 1'b0;
			pen_q       <= '0;
			widest_q    <= '0;
			height_q    <= '0;
			misses_q    <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc_measure) begin
						in_string_q <= 1'b1;
						pen_q       <= pen_b;
						widest_q    <= widest_b;
						misses_q    <= misses_b;
						height_q    <= height_b;
						if (in_code == CODE_END) begin
							state_q <= ST_FINISH;
						end else if (in_code == CODE_LF || in_code == CODE_CR) begin
							if (measure_mode_q == MODE_LINE) begin
								state_q <= ST_FINISH;
							end else if (in_code == CODE_LF) begin
								pen_q    <= '0;
								height_q <= height_lf;
							end
						end else if (n_slots == '0) begin
							misses_q <= misses_b_inc;
						end else begin
							state_q <= ST_PROBE;
						end
					end
				end
				ST_PROBE: begin
					if (probe_hit) begin
						state_q <= ST_ACC;
					end else if (probe_miss) begin
						misses_q <= misses_q_inc;
						state_q  <= ST_IDLE;
					end
				end
				ST_ACC: begin
					pen_q <= pen_next;
					if (!pen_next[PEN_W-1] && (pen_next[WID_W-1:0] > widest_q)) begin
						widest_q <= pen_next[WID_W-1:0];
					end
					state_q <= ST_IDLE;
				end
				ST_FINISH: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q  <= 1'b1;
						in_string_q <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// search bounds, latched code and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			lo_q   <= '0;
			hi_q   <= hi_init;
			mid_q  <= hi_init >> 1;
			code_q <= in_code;
		end else if (state_q == ST_PROBE && !probe_hit && !probe_miss) begin
			if (probe_gt) begin
				lo_q <= lo_up[SLOT_W-1:0];
			end else begin
				hi_q <= hi_dn;
			end
			mid_q <= probe_mid;
		end
		if (state_q == ST_FINISH && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= OUT_W'({misses_q, height_q, widest_q});
		end
	end

	// checks
	`GTM_AST_ALWAYS(a_probe_bounds, clk, arst_n,
		(state_q != ST_PROBE) || ((lo_q <= mid_q) && (mid_q <= hi_q)))
	`GTM_AST_IMPL(a_result_from_finish, clk, arst_n, $rose(m_tvalid_q),
		$past(state_q) == ST_FINISH)
	`GTM_AST_IMPL(a_string_closes_on_result, clk, arst_n, $fell(in_string_q),
		m_tvalid_q)
	`GTM_AST_IMPL(a_no_read_on_write, clk, arst_n, wr_en, !rd_en)

endmodule

// File: test/glyph_text_measure_top_tb.sv
`timescale 1ns / 100ps
// Testbench for glyph_text_measure_top: loads glyph tables, streams characters,
// predicts width, height and miss count of each string and checks every result.
// Depends on gtm_pkg and the glyph_text_measure_top RTL.
module glyph_text_measure_top_tb;
	import gtm_pkg::*;

	localparam int CLK_PERIOD    = 4;
	localparam int RESET_CYCLES  = 7;
	// longest item is a full search: 9 probes, then the accumulate step
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_LIMIT   = 4000;
	localparam int RANDOM_ITEMS  = 450;
	localparam int PHASE_ITEMS   = 150;
	localparam int BURST_ITEMS   = 60;
	localparam int WIDE_SLOT     = 100;
	localparam int NARROW_SLOT   = 101;
	localparam int PEN_MAX       = 8388607;
	localparam int PEN_MIN       = -8388608;
	localparam logic [CODE_W-1:0] CODE_TOP   = 21'd1114111;
	localparam logic [ADV_W-1:0]  ADV_MAX    = 12'h7FF;
	localparam logic [ADV_W-1:0]  ADV_MIN    = 12'h800;
	localparam logic              MODE_WHOLE = 1'b0;

	typedef struct {
		logic              op;
		logic [IDX_W-1:0]  idx;
		logic [CODE_W-1:0] code;
		logic [ADV_W-1:0]  adv;
	} glyph_item_t;

	typedef struct {
		logic [WID_W-1:0]  width;
		logic [HGT_W-1:0]  height;
		logic [MISS_W-1:0] misses;
	} text_extent_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata   = '0;
	logic             s_tuser   = OP_LOAD;
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [1:0]       cfg_index = REG_LINE_HEIGHT;
	logic [LH_W-1:0]  cfg_data  = '0;

	glyph_text_measure_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// item flow and bookkeeping
	glyph_item_t  pending_items[$];
	text_extent_t extent_queue[$];
	glyph_item_t  offer;
	logic [CODE_W-1:0] slot_code [GLYPH_SLOTS];
	int  sent_count   = 0;
	int  taken_count  = 0;
	int  extents_seen = 0;
	int  reg_writes   = 0;
	int  errors       = 0;
	int  quiet_cycles = 0;
	int  send_gap     = 0;
	int  recv_gap     = 0;
	int  hold_left    = 0;
	bit  item_taken   = 0;
	bit  extent_taken = 0;
	bit  reg_taken    = 0;
	bit  hold_request = 0;
	bit  send_idle    = 1;
	bit  recv_idle    = 1;

	// predicted block state
	logic [LH_W-1:0]   lh_reg   = '0;
	logic [GC_W-1:0]   gc_reg   = '0;
	logic              mode_reg = MODE_WHOLE;
	logic [CODE_W-1:0] pred_code [GLYPH_SLOTS];
	logic [ADV_W-1:0]  pred_adv  [GLYPH_SLOTS];
	int                pen_pos    = 0;
	logic [WID_W-1:0]  widest_pos = '0;
	logic [HGT_W-1:0]  height_acc = '0;
	logic [MISS_W-1:0] miss_acc   = '0;
	bit                text_open  = 0;

	// apply one accepted item; a finished string queues its extent
	task automatic predict_extent(input glyph_item_t it);
		int lo, hi, mid, n, step, p;
		bit found;
		logic [HGT_W:0] hsum;
		text_extent_t res;
		if (it.op == OP_LOAD) begin
			pred_code[it.idx] = it.code;
			pred_adv[it.idx]  = it.adv;
		end else begin
			if (!text_open) begin
				pen_pos    = 0;
				widest_pos = '0;
				miss_acc   = '0;
				height_acc = HGT_W'(lh_reg);
				text_open  = 1;
			end
			if (it.code == CODE_END ||
					(mode_reg == MODE_LINE && (it.code == CODE_LF || it.code == CODE_CR))) begin
				res.width  = widest_pos;
				res.height = height_acc;
				res.misses = miss_acc;
				extent_queue.push_back(res);
				text_open = 0;
			end else if (it.code == CODE_LF) begin
				pen_pos = 0;
				hsum = height_acc + lh_reg;
				height_acc = (hsum > HEIGHT_MAX) ? HEIGHT_MAX : hsum[HGT_W-1:0];
			end else if (it.code != CODE_CR) begin
				// binary search over the valid part of the table
				n = (gc_reg > GLYPH_SLOTS) ? GLYPH_SLOTS : gc_reg;
				lo = 0;
				hi = n - 1;
				found = 0;
				step = 0;
				while (lo <= hi && !found) begin
					mid = (lo + hi) / 2;
					if (it.code > pred_code[mid]) begin
						lo = mid + 1;
					end else if (it.code < pred_code[mid]) begin
						hi = mid - 1;
					end else begin
						found = 1;
						step = $signed(pred_adv[mid]);
					end
				end
				if (found) begin
					p = pen_pos + step;
					if (p > PEN_MAX) p = PEN_MAX;
					if (p < PEN_MIN) p = PEN_MIN;
					pen_pos = p;
					if (p > 0 && p > int'(widest_pos)) widest_pos = p[WID_W-1:0];
				end else if (miss_acc != MISS_MAX) begin
					miss_acc++;
				end
			end
		end
	endtask

	task automatic push_item(input logic op, input int unsigned idx,
			input int unsigned code, input int unsigned adv);
		glyph_item_t it;
		it.op   = op;
		it.idx  = idx[IDX_W-1:0];
		it.code = code[CODE_W-1:0];
		it.adv  = adv[ADV_W-1:0];
		pending_items.push_back(it);
		sent_count++;
	endtask

	task automatic push_load(input int unsigned idx, input int unsigned code,
			input int unsigned adv);
		slot_code[idx[IDX_W-1:0]] = code[CODE_W-1:0];
		push_item(OP_LOAD, idx, code, adv);
	endtask

	// measure item; slot and advance fields are don't-care, so randomised
	task automatic push_char(input int unsigned code);
		push_item(OP_MEASURE, $urandom_range(0, 255), code, $urandom_range(0, 4095));
	endtask

	// ascending codes over the whole table, last one the top code point
	task automatic load_sorted_table();
		int unsigned c, a;
		int i;
		c = $urandom_range(14, 100);
		for (i = 0; i < GLYPH_SLOTS; i++) begin
			if (i == GLYPH_SLOTS - 1) c = CODE_TOP;
			if (i == WIDE_SLOT) a = ADV_MAX;
			else if (i == NARROW_SLOT) a = ADV_MIN;
			else a = $urandom_range(0, 4095);
			push_load(i, c, a);
			c += $urandom_range(1, 4000);
		end
	endtask

	// code of a loaded glyph inside the searched range, or a random code if that range is empty
	function automatic logic [CODE_W-1:0] pick_glyph();
		int n;
		n = (gc_reg > GLYPH_SLOTS) ? GLYPH_SLOTS : gc_reg;
		if (n == 0) return CODE_W'($urandom_range(14, CODE_TOP));
		return slot_code[SLOT_W'($urandom_range(0, n - 1))];
	endfunction

	// all items in, all results out, then let the block settle
	task automatic wait_idle();
		while (sent_count != taken_count || extent_queue.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_reg(input logic [1:0] ri, input int unsigned v);
		wait_idle();
		cfg_index <= ri;
		cfg_data  <= v[LH_W-1:0];
		cfg_valid <= 1'b1;
		do @(negedge clk); while (!reg_taken);
		reg_taken = 0;
		cfg_valid <= 1'b0;
	endtask

	// sender: one item at a time from the pending queue
	always @(negedge clk) begin : sender
		logic nv;
		logic [IN_W-1:0] word;
		nv = s_tvalid;
		if (arst_n) begin
			if (item_taken) begin
				item_taken = 0;
				nv = 1'b0;
				send_gap = send_idle ? $urandom_range(0, 19) : 0;
			end
			if (!nv) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_items.size() > 0) begin
					offer = pending_items.pop_front();
					word = '0;
					word[IN_BITS-1:0] = {offer.adv, offer.code, offer.idx};
					s_tdata <= word;
					s_tuser <= offer.op;
					nv = 1'b1;
				end
			end
		end
		s_tvalid <= nv;
	end

	// receiver: random stalls, plus one long hold-off on request
	always @(negedge clk) begin : receiver
		if (arst_n) begin
			if (extent_taken) begin
				extent_taken = 0;
				recv_gap = recv_idle ? $urandom_range(0, 19) : 0;
			end
			if (hold_request) begin
				hold_request = 0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// accepted items and register writes feed the predictor
	always @(posedge clk) begin : accept
		if (arst_n && s_tvalid && s_tready) begin
			predict_extent(offer);
			item_taken = 1;
			taken_count++;
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LINE_HEIGHT:  lh_reg   = cfg_data;
				REG_GLYPH_COUNT:  gc_reg   = cfg_data[GC_W-1:0];
				REG_MEASURE_MODE: mode_reg = cfg_data[0];
				default: ;
			endcase
			reg_taken = 1;
			reg_writes++;
		end
	end

	// result check against the oldest predicted extent
	always @(posedge clk) begin : monitor
		text_extent_t want;
		logic [WID_W-1:0]  got_w;
		logic [HGT_W-1:0]  got_h;
		logic [MISS_W-1:0] got_m;
		if (arst_n && m_tvalid && m_tready) begin
			extent_taken = 1;
			extents_seen++;
			got_w = m_tdata[WID_W-1:0];
			got_h = m_tdata[WID_W +: HGT_W];
			got_m = m_tdata[WID_W + HGT_W +: MISS_W];
			if (extent_queue.size() == 0) begin
				$error("text extent arrived with none expected: width %0d height %0d misses %0d",
					got_w, got_h, got_m);
				errors++;
			end else begin
				want = extent_queue.pop_front();
				if (got_w !== want.width) begin
					$error("text_width expected %0d actual %0d", want.width, got_w);
					errors++;
				end
				if (got_h !== want.height) begin
					$error("text_height expected %0d actual %0d", want.height, got_h);
					errors++;
				end
				if (got_m !== want.misses) begin
					$error("miss_count expected %0d actual %0d", want.misses, got_m);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("no handshake for %0d cycles", QUIET_LIMIT);
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int i, n, r, v, ph, phase_cnt, rand_items;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// empty table: empty string, miss, line feed, carriage return
		set_reg(REG_LINE_HEIGHT, 16);
		set_reg(REG_GLYPH_COUNT, 0);
		set_reg(REG_MEASURE_MODE, MODE_WHOLE);
		push_char(CODE_END);
		push_char(65);
		push_char(CODE_LF);
		push_char(CODE_CR);
		push_char(CODE_END);
		load_sorted_table();

		// full table: first and last entry, both advance extremes, a miss, CR and line feed
		set_reg(REG_GLYPH_COUNT, GLYPH_SLOTS);
		set_reg(REG_LINE_HEIGHT, 1023);
		push_char(slot_code[0]);
		push_char(slot_code[GLYPH_SLOTS - 1]);
		push_char(slot_code[WIDE_SLOT]);
		push_char(slot_code[NARROW_SLOT]);
		push_char(CODE_TOP - 1);
		push_char(CODE_CR);
		push_char(CODE_LF);
		push_char(slot_code[WIDE_SLOT]);
		push_char(CODE_END);

		// stop at first line end, including an empty line
		set_reg(REG_MEASURE_MODE, MODE_LINE);
		push_char(slot_code[WIDE_SLOT]);
		push_char(CODE_LF);
		push_char(CODE_CR);
		push_char(slot_code[50]);
		push_char(slot_code[NARROW_SLOT]);
		push_char(CODE_CR);

		// oversized and tiny glyph counts, zero line height
		set_reg(REG_MEASURE_MODE, MODE_WHOLE);
		set_reg(REG_LINE_HEIGHT, 0);
		set_reg(REG_GLYPH_COUNT, 511);
		push_char(slot_code[GLYPH_SLOTS - 1]);
		push_char(slot_code[200]);
		push_char(CODE_LF);
		push_char(CODE_END);
		set_reg(REG_GLYPH_COUNT, 1);
		push_char(slot_code[0]);
		push_char(slot_code[1]);
		push_char(CODE_END);

		// back-to-back runs: long pen walks both ways, many line feeds, many misses
		send_idle = 0;
		recv_idle = 0;
		set_reg(REG_GLYPH_COUNT, GLYPH_SLOTS);
		set_reg(REG_LINE_HEIGHT, 5);
		for (i = 0; i < BURST_ITEMS; i++) push_char(slot_code[WIDE_SLOT]);
		push_char(CODE_END);
		// negative pen never widens
		for (i = 0; i < BURST_ITEMS; i++) push_char(slot_code[NARROW_SLOT]);
		push_char(slot_code[WIDE_SLOT]);
		push_char(CODE_END);
		set_reg(REG_LINE_HEIGHT, 1023);
		for (i = 0; i < BURST_ITEMS; i++) push_char(CODE_LF);
		push_char(CODE_END);
		set_reg(REG_GLYPH_COUNT, 0);
		for (i = 0; i < BURST_ITEMS + 30; i++) push_char($urandom_range(14, CODE_TOP));
		push_char(CODE_END);

		// random phases: mostly whole strings, some stray codes and table writes
		rand_items = 0;
		ph = 0;
		while (rand_items < RANDOM_ITEMS) begin
			send_idle = ($urandom_range(0, 4) != 0);
			recv_idle = ($urandom_range(0, 4) != 0);
			r = $urandom_range(0, 3);
			v = (r == 0) ? 0 : (r == 1) ? 1023 : $urandom_range(1, 1022);
			set_reg(REG_LINE_HEIGHT, v);
			case ($urandom_range(0, 9))
				0: v = 0;
				1: v = 1;
				2: v = 2;
				3: v = 511;
				4, 5: v = GLYPH_SLOTS;
				default: v = $urandom_range(1, GLYPH_SLOTS);
			endcase
			set_reg(REG_GLYPH_COUNT, v);
			set_reg(REG_MEASURE_MODE, ($urandom_range(0, 2) == 0) ? MODE_LINE : MODE_WHOLE);
			if (ph == 3) begin
				load_sorted_table();
				rand_items += GLYPH_SLOTS;
			end
			// long output stall while terminators keep coming
			if (ph == 1) begin
				hold_request = 1;
				for (i = 0; i < 40; i++) push_char(CODE_END);
				rand_items += 40;
			end
			phase_cnt = 0;
			while (phase_cnt < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 4) begin
					push_load($urandom_range(0, 255), $urandom_range(0, CODE_TOP),
						$urandom_range(0, 4095));
					phase_cnt++;
				end else if (r < 9) begin
					case ($urandom_range(0, 2))
						0: push_char(CODE_LF);
						1: push_char(CODE_CR);
						default: push_char(CODE_END);
					endcase
					phase_cnt++;
				end else begin
					n = $urandom_range(0, 10);
					for (i = 0; i < n; i++) begin
						r = $urandom_range(0, 99);
						if (r < 75) push_char(pick_glyph());
						else if (r < 87) push_char($urandom_range(14, CODE_TOP));
						else if (r < 95) push_char(CODE_LF);
						else push_char(CODE_CR);
					end
					push_char(CODE_END);
					phase_cnt += n + 1;
				end
			end
			rand_items += phase_cnt;
			ph++;
		end
		wait_idle();

		$display("%0d items accepted, %0d register writes, %0d text extents checked",
			taken_count, reg_writes, extents_seen);
		$display("covered line-end mode, odd glyph counts, advance extremes, back-to-back items, stalls");
		if (errors == 0 && extent_queue.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

// File: glyph_text_measure_top.f
+incdir+design
design/gtm_pkg.sv
design/glyph_text_measure_top.sv
test/glyph_text_measure_top_tb.sv
